### rtl/core/rfifo_pkg.sv
// ----------------------------------------------------------------------------
// rfifo_pkg
// Types and constants shared by the ring FIFO with overwrite or discard on full
// ----------------------------------------------------------------------------
`default_nettype none

package rfifo_pkg;

	localparam int DATA_W    = 32;
	localparam int CNT_W     = 5;
	localparam int DEPTH_DEF = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 5;

	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(10);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OVERFLOW_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY      = 1'd1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_REFUSED = 2'd1,
		ST_EMPTY   = 2'd2
	} status_t;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [DATA_W-1:0] data_in;
	} cmd_t;

	typedef struct packed {
		status_t           status;
		logic [DATA_W-1:0] data_out;
		logic              overwrote;
		logic [CNT_W-1:0]  fill_count;
		logic              push_ready;
	} result_t;

endpackage

`default_nettype wire

### rtl/core/ring_fifo_overwrite_or_discard.sv
// ----------------------------------------------------------------------------
// ring_fifo_overwrite_or_discard
// Circular FIFO with run-time capacity; a push on full overwrites the oldest
// entry or is refused, as the overflow mode register selects
// ----------------------------------------------------------------------------
// the result of an accepted command is registered and shows on result, with
// done high, in the cycle after the command is accepted
// throughput: one command per cycle; busy stays low, the receiver cannot stall
// reset: pointers and fill count clear, overflow mode 0, capacity 10;
// entry storage is not cleared and holds garbage until written
`default_nettype none

module ring_fifo_overwrite_or_discard
	import rfifo_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire cmd_t                 cmd,
	output logic                      done,
	output result_t                   result,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int WW = (PW + 1 > CNT_W) ? PW + 1 : CNT_W;

	logic              mode_q;
	logic [CNT_W-1:0]  capacity_q;
	logic [PW-1:0]     wp_q;
	logic [PW-1:0]     rp_q;
	logic [CNT_W-1:0]  held_q;
	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_q;

	logic              done_q;
	status_t           status_q;
	logic              pop_ok_q;
	logic              ovw_q;
	logic [CNT_W-1:0]  fill_q;
	logic              pr_q;

	logic              acc;
	logic [WW-1:0]     cap_w;
	logic [WW-1:0]     cap_eff;
	logic              full;
	logic              is_push;
	logic              push_ok;
	logic              pop_ok;
	logic [WW-1:0]     wp_inc;
	logic [WW-1:0]     rp_inc;
	logic [PW-1:0]     wp_adv;
	logic [PW-1:0]     rp_adv;
	logic [PW-1:0]     wp_nxt;
	logic [PW-1:0]     rp_nxt;
	logic [CNT_W-1:0]  held_nxt;
	status_t           status_nxt;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign acc       = start & ~busy;

	always_comb begin
		cap_w = WW'(capacity_q);
		if (cap_w == '0) begin
			cap_eff = WW'(1);
		end else if (cap_w > WW'(DEPTH)) begin
			cap_eff = WW'(DEPTH);
		end else begin
			cap_eff = cap_w;
		end
	end

	assign full    = WW'(held_q) >= cap_eff;
	assign is_push = (cmd.op == OP_PUSH);
	assign push_ok = is_push && !(full && mode_q);
	assign pop_ok  = !is_push && (held_q != '0);

	assign wp_inc = WW'(wp_q) + WW'(1);
	assign rp_inc = WW'(rp_q) + WW'(1);
	assign wp_adv = (wp_inc >= cap_eff) ? '0 : wp_inc[PW-1:0];
	assign rp_adv = (rp_inc >= cap_eff) ? '0 : rp_inc[PW-1:0];

	always_comb begin
		wp_nxt     = wp_q;
		rp_nxt     = rp_q;
		held_nxt   = held_q;
		status_nxt = ST_OK;
		if (is_push) begin
			if (push_ok) begin
				wp_nxt = wp_adv;
				if (full) begin
					rp_nxt   = rp_adv;
					held_nxt = cap_eff[CNT_W-1:0];
				end else begin
					held_nxt = held_q + CNT_W'(1);
				end
			end else begin
				status_nxt = ST_REFUSED;
			end
		end else begin
			if (pop_ok) begin
				rp_nxt   = rp_adv;
				held_nxt = held_q - CNT_W'(1);
			end else begin
				status_nxt = ST_EMPTY;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b0;
			capacity_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_OVERFLOW_MODE: mode_q     <= cfg_data[0];
				REG_CAPACITY:      capacity_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// pointers, count and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			held_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= acc;
			if (acc) begin
				wp_q   <= wp_nxt;
				rp_q   <= rp_nxt;
				held_q <= held_nxt;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (acc && push_ok) begin
			mem[wp_q] <= cmd.data_in;
		end
		if (acc && pop_ok) begin
			rd_q <= mem[rp_q];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (acc) begin
			status_q <= status_nxt;
			pop_ok_q <= pop_ok;
			ovw_q    <= push_ok && full;
			fill_q   <= held_nxt;
			pr_q     <= (WW'(held_nxt) < cap_eff) || !mode_q;
		end
	end

	assign done              = done_q;
	assign result.status     = status_q;
	assign result.data_out   = pop_ok_q ? rd_q : '0;
	assign result.overwrote  = ovw_q;
	assign result.fill_count = fill_q;
	assign result.push_ready = pr_q;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done)
		else $error("accepted transaction gave no result");

	a_ovw_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.overwrote |-> result.status == ST_OK && result.data_out == '0)
		else $error("overwrite flagged on a failed or pop transaction");

	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == ST_REFUSED |-> !result.push_ready)
		else $error("refused push but push_ready high");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == ST_EMPTY |-> result.fill_count == '0)
		else $error("empty pop with nonzero fill count");

endmodule

`default_nettype wire

### bench/ring_fifo_overwrite_or_discard_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ring_fifo_overwrite_or_discard_tb
// Self-checking bench for the ring FIFO with overwrite or discard on full.
// A mirror of the FIFO state predicts one result per accepted command and
// checks each strobed result against the oldest prediction. A short directed
// sequence covers empty pops, overwrite and refusal on full, capacity zero,
// capacity above the storage depth and capacity cut below the fill count.
// Random traffic then runs over many register settings with varying push bias
// and sender gaps.
// ----------------------------------------------------------------------------

module ring_fifo_overwrite_or_discard_tb
	import rfifo_pkg::*;
;

	localparam int CYCLE_LIMIT = 200000;
	localparam int ITEMS_PER_SETTING = 100;

	class ring_mirror;
		logic              mode;
		logic [CNT_W-1:0]  cap;
		logic [3:0]        wptr;
		logic [3:0]        rptr;
		logic [CNT_W-1:0]  held;
		logic [DATA_W-1:0] store [DEPTH_DEF];
		bit                written [DEPTH_DEF];
		result_t           expected_results [$];
		int                mismatches;
		int                checked;
		int                n_push;
		int                n_pop;
		int                n_over;
		int                n_refused;
		int                n_empty;

		function new();
			mode = 1'b0;
			cap = CAP_RESET;
			wptr = '0;
			rptr = '0;
			held = '0;
			foreach (written[i]) written[i] = 1'b0;
			mismatches = 0;
			checked = 0;
			n_push = 0;
			n_pop = 0;
			n_over = 0;
			n_refused = 0;
			n_empty = 0;
		endfunction

		function int eff_cap();
			if (cap == 0)
				return 1;
			if (cap > DEPTH_DEF)
				return DEPTH_DEF;
			return int'(cap);
		endfunction

		function logic [3:0] next_ptr(logic [3:0] p, int lim);
			int n;
			n = int'(p) + 1;
			return (n >= lim) ? 4'd0 : 4'(n);
		endfunction

		// a pop must never land on a slot that was never written
		function bit pop_is_safe();
			return (held == 0) || written[rptr];
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		function void note_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
			if (idx == REG_OVERFLOW_MODE)
				mode = d[0];
			else if (idx == REG_CAPACITY)
				cap = d;
		endfunction

		function void note_cmd(cmd_t c);
			result_t r;
			int lim;
			bit full;
			lim = eff_cap();
			full = int'(held) >= lim;
			r = '0;
			r.status = ST_OK;
			if (c.op == OP_PUSH) begin
				n_push++;
				if (full && mode) begin
					r.status = ST_REFUSED;
					n_refused++;
				end else begin
					store[wptr] = c.data_in;
					written[wptr] = 1'b1;
					wptr = next_ptr(wptr, lim);
					if (full) begin
						r.overwrote = 1'b1;
						rptr = next_ptr(rptr, lim);
						held = CNT_W'(lim);
						n_over++;
					end else begin
						held = held + 1'b1;
					end
				end
			end else begin
				n_pop++;
				if (held == 0) begin
					r.status = ST_EMPTY;
					n_empty++;
				end else begin
					r.data_out = store[rptr];
					rptr = next_ptr(rptr, lim);
					held = held - 1'b1;
				end
			end
			r.fill_count = held;
			r.push_ready = (int'(held) < lim) || !mode;
			expected_results.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d data %h over %b fill %0d ready %b",
						got.status, got.data_out, got.overwrote, got.fill_count,
						got.push_ready);
			end else begin
				want = expected_results.pop_front();
				if (got.status !== want.status || got.data_out !== want.data_out ||
						got.overwrote !== want.overwrote ||
						got.fill_count !== want.fill_count ||
						got.push_ready !== want.push_ready) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch at result %0d", checked);
						$display("  expected status %0d data %h over %b fill %0d ready %b",
							want.status, want.data_out, want.overwrote, want.fill_count,
							want.push_ready);
						$display("  actual   status %0d data %h over %b fill %0d ready %b",
							got.status, got.data_out, got.overwrote, got.fill_count,
							got.push_ready);
					end
				end
				checked++;
			end
		endfunction

		function void close();
			if (expected_results.size() != 0) begin
				$display("%0d results never arrived", expected_results.size());
				mismatches += expected_results.size();
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	cmd_t                 cmd;
	logic                 done;
	result_t              result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	ring_mirror mirror = new();
	int         gap_pct;
	int         settings_done;
	int         cycles;

	ring_fifo_overwrite_or_discard u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				mirror.note_cfg(cfg_index, cfg_data);
			if (start && !busy)
				mirror.note_cmd(cmd);
			if (done)
				mirror.check_result(result);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// entered and left at a falling edge
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (mirror.pending() != 0);
		@(negedge clk);
	endtask

	task automatic configure(input logic mode, input logic [CFG_DAT_W-1:0] cap);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= REG_OVERFLOW_MODE;
		cfg_data  <= {4'($urandom), mode};
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_index <= REG_CAPACITY;
		cfg_data  <= cap;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings_done++;
	endtask

	task automatic send_cmd(input op_t op, input logic [DATA_W-1:0] data);
		cmd_t c;
		c.op = (op == OP_POP && !mirror.pop_is_safe()) ? OP_PUSH : op;
		c.data_in = data;
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic push(input logic [DATA_W-1:0] data);
		send_cmd(OP_PUSH, data);
	endtask

	task automatic pop();
		send_cmd(OP_POP, DATA_W'($urandom));
	endtask

	task automatic run_directed();
		gap_pct = 0;
		pop();
		push('0);
		push('1);
		pop();
		pop();
		pop();
		// overwrite on full
		configure(1'b0, 5'd2);
		push(32'h1111_1111);
		push(32'h2222_2222);
		push(32'h3333_3333);
		pop();
		pop();
		// refusal on full
		configure(1'b1, 5'd2);
		push(32'hA5A5_A5A5);
		push(32'h5A5A_5A5A);
		push(32'hDEAD_BEEF);
		pop();
		// capacity zero acts as one
		configure(1'b1, 5'd0);
		push(32'h0000_0001);
		configure(1'b0, 5'd0);
		push(32'h8000_0000);
		pop();
		// capacity cut below the fill count
		configure(1'b0, 5'd16);
		repeat (5) push(DATA_W'($urandom));
		configure(1'b0, 5'd3);
		pop();
		push(32'hCAFE_F00D);
		pop();
		// capacity above the storage depth
		configure(1'b1, 5'd31);
		push(32'h7FFF_FFFF);
		pop();
	endtask

	task automatic run_random();
		logic                 modes [12] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0,
			1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
		logic [CFG_DAT_W-1:0] caps  [12] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd10,
			5'd17, 5'd5, 5'd3, 5'd16, 5'd8, 5'd1};
		int                   push_pct;
		logic [DATA_W-1:0]    data;
		op_t                  op;
		for (int p = 0; p < 12; p++) begin
			gap_pct = (p < 4) ? 9 : (p < 8) ? 68 : 0;
			configure(modes[p], caps[p]);
			push_pct = 50;
			for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
				if (i % 25 == 0)
					case ($urandom_range(3))
						0: push_pct = 25;
						1: push_pct = 50;
						2: push_pct = 75;
						default: push_pct = 90;
					endcase
				if ($urandom_range(49) == 0)
					drain();
				case ($urandom_range(7))
					0: data = '0;
					1: data = '1;
					default: data = DATA_W'($urandom);
				endcase
				op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
				send_cmd(op, data);
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		cmd       = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		gap_pct   = 0;
		settings_done = 0;
		cycles    = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		run_directed();
		run_random();

		drain();
		repeat (4) @(posedge clk);
		mirror.close();
		$display("checked %0d results over %0d register settings", mirror.checked,
			settings_done);
		$display("%0d pushes, %0d pops, %0d overwrites, %0d refused, %0d empty pops",
			mirror.n_push, mirror.n_pop, mirror.n_over, mirror.n_refused, mirror.n_empty);
		if (mirror.mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches", mirror.mismatches);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

### files.f
rtl/core/rfifo_pkg.sv
rtl/core/ring_fifo_overwrite_or_discard.sv
bench/ring_fifo_overwrite_or_discard_tb.sv
